FILE: src/ilie_pkg.sv
// ============================================================================
// ilie_pkg
// Shared types and constants for the indexed list insert/erase core.
// ============================================================================
package ilie_pkg;

    localparam int BLOCK_ENTRIES = 5;
    localparam int MAX_BLOCKS    = 16;
    localparam int POS_W         = 7;
    localparam int VAL_W         = 32;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_ERASE  = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

FILE: src/ilie_cell.sv
// ============================================================================
// ilie_cell
// One list slot: loads a new value, takes its lower neighbor on insert, or
// takes its upper neighbor on erase.
// ============================================================================
module ilie_cell #(
    parameter int IDX_W = 7,
    parameter int IDX   = 0
) (
    input  logic                      i_clk,
    input  ilie_pkg::t_cell_ctl       i_ctl,
    input  logic [IDX_W-1:0]          i_pos,
    input  logic [ilie_pkg::VAL_W-1:0] i_prev,
    input  logic [ilie_pkg::VAL_W-1:0] i_next,
    output logic [ilie_pkg::VAL_W-1:0] o_data,
    output logic [ilie_pkg::VAL_W-1:0] o_sel
);

    logic [ilie_pkg::VAL_W-1:0] r_data;
    logic [ilie_pkg::VAL_W-1:0] n_data;
    logic                       w_hit;
    logic                       w_above;

    assign w_hit   = (i_pos == IDX_W'(IDX));
    assign w_above = (IDX_W'(IDX) > i_pos);

    always_comb begin
        n_data = r_data;
        priority if (i_ctl.ins && w_hit) begin
            n_data = i_ctl.value;
        end else if (i_ctl.ins && w_above) begin
            n_data = i_prev;
        end else if (i_ctl.del && (w_hit || w_above)) begin
            n_data = i_next;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_sel  = w_hit ? r_data : '0;

endmodule

FILE: src/indexed_list_insert_erase_core.sv
// ============================================================================
// indexed_list_insert_erase_core
// Result: the result beat is registered and valid in the cycle after the request beat is accepted.
// Throughput: one request per cycle unless the result side stalls; the whole shift is done by the cell row.
// Reset: count, block count and result valid clear to zero; list slots are not cleared.
// ============================================================================
module indexed_list_insert_erase_core #(
    parameter int BLOCK_ENTRIES = ilie_pkg::BLOCK_ENTRIES,
    parameter int MAX_BLOCKS    = ilie_pkg::MAX_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[6:0], item_value[38:7], pad
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // read_data[31:0], entry_count[38:32],
                                        // capacity_now[45:39], pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int LIST_CAP = BLOCK_ENTRIES * MAX_BLOCKS;
    localparam int CNT_W    = $clog2(LIST_CAP + 1);
    localparam int BLK_W    = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W    = (CNT_W > ilie_pkg::POS_W) ? CNT_W : ilie_pkg::POS_W;
    localparam int VW       = ilie_pkg::VAL_W;

    logic [CNT_W-1:0] r_count,  n_count;
    logic [BLK_W-1:0] r_blocks, n_blocks;
    logic             r_out_valid;
    logic [47:0]      r_out_tdata, n_out_tdata;
    logic [1:0]       r_out_tuser;

    ilie_pkg::t_req      w_req;
    ilie_pkg::t_status   w_status;
    ilie_pkg::t_cell_ctl w_ctl;
    logic                w_accept;
    logic [CMP_W-1:0]    w_pos, w_cnt, w_cap_cur, w_cap_new;
    logic [BLK_W:0]      w_dbl;
    logic [BLK_W-1:0]    w_grow_blocks;
    logic                w_has_room, w_not_full, w_ok;
    logic [CNT_W-1:0]    w_cell_pos;
    logic [VW-1:0]       w_rd_or, w_rdata;
    logic [VW-1:0]       w_data [LIST_CAP];
    logic [VW-1:0]       w_sel  [LIST_CAP];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_req         = ilie_pkg::t_req'(s_axis_tuser);
    assign w_pos         = CMP_W'(s_axis_tdata[6:0]);
    assign w_cnt         = CMP_W'(r_count);
    assign w_cap_cur     = CMP_W'(r_blocks) * CMP_W'(BLOCK_ENTRIES);
    assign w_has_room    = w_cnt < w_cap_cur;
    assign w_not_full    = w_cnt < CMP_W'(LIST_CAP);
    assign w_dbl         = {r_blocks, 1'b0};
    assign w_grow_blocks = (r_blocks == '0) ? BLK_W'(1) :
                           (w_dbl > (BLK_W+1)'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS) :
                           w_dbl[BLK_W-1:0];

    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < LIST_CAP; i++) begin
            w_rd_or = w_rd_or | w_sel[i];
        end
    end

    always_comb begin
        w_status   = ilie_pkg::ST_OK;
        w_ok       = 1'b0;
        w_rdata    = '0;
        n_count    = r_count;
        n_blocks   = r_blocks;
        w_cell_pos = w_pos[CNT_W-1:0];
        unique case (w_req)
            ilie_pkg::REQ_APPEND: begin
                w_cell_pos = r_count;
                if (!w_has_room && !w_not_full) begin
                    w_status = ilie_pkg::ST_FULL;
                end else begin
                    w_ok    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (!w_has_room) begin
                        n_blocks = w_grow_blocks;
                    end
                end
            end
            ilie_pkg::REQ_INSERT: begin
                priority if (w_pos > w_cnt) begin
                    w_status = ilie_pkg::ST_RANGE;
                end else if (!w_has_room && !w_not_full) begin
                    w_status = ilie_pkg::ST_FULL;
                end else begin
                    w_ok    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (!w_has_room) begin
                        n_blocks = w_grow_blocks;
                    end
                end
            end
            ilie_pkg::REQ_ERASE: begin
                if (w_pos >= w_cnt) begin
                    w_status = ilie_pkg::ST_RANGE;
                end else begin
                    w_ok    = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            ilie_pkg::REQ_READ: begin
                if (w_pos >= w_cnt) begin
                    w_status = ilie_pkg::ST_RANGE;
                end else begin
                    w_rdata = w_rd_or;
                end
            end
            default: begin
                w_status = ilie_pkg::ST_OK;
            end
        endcase
    end

    assign w_ctl.ins   = w_accept && w_ok &&
                         ((w_req == ilie_pkg::REQ_APPEND) || (w_req == ilie_pkg::REQ_INSERT));
    assign w_ctl.del   = w_accept && w_ok && (w_req == ilie_pkg::REQ_ERASE);
    assign w_ctl.value = s_axis_tdata[38:7];

    genvar g;
    generate
        for (g = 0; g < LIST_CAP; g++) begin : g_cell
            logic [VW-1:0] w_prev;
            logic [VW-1:0] w_next;
            if (g == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_lo
                assign w_prev = w_data[g-1];
            end
            if (g == LIST_CAP - 1) begin : g_last
                assign w_next = w_data[g];
            end else begin : g_mid_hi
                assign w_next = w_data[g+1];
            end
            ilie_cell #(
                .IDX_W (CNT_W),
                .IDX   (g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_pos  (w_cell_pos),
                .i_prev (w_prev),
                .i_next (w_next),
                .o_data (w_data[g]),
                .o_sel  (w_sel[g])
            );
        end
    endgenerate

    assign w_cap_new = CMP_W'(n_blocks) * CMP_W'(BLOCK_ENTRIES);

    always_comb begin
        n_out_tdata        = '0;
        n_out_tdata[31:0]  = w_rdata;
        n_out_tdata[38:32] = 7'(n_count);
        n_out_tdata[45:39] = w_cap_new[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_blocks    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_blocks    <= n_blocks;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= w_cap_cur)
        else $error("entry count above capacity");

    a_blocks_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blocks <= BLK_W'(MAX_BLOCKS))
        else $error("block count above bound");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> m_axis_tvalid)
        else $error("no result beat after request beat");

    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (CMP_W'(m_axis_tdata[38:32]) == (CMP_W'(r_count) & CMP_W'(7'h7f))))
        else $error("reported count differs from stored count");

endmodule

FILE: tb/indexed_list_insert_erase_core_test.sv
// ============================================================================
// indexed_list_insert_erase_core_test
// Self-checking bench for the indexed list core. A directed table covers
// the empty list, index limits, value extremes and the first block growth.
// Random traffic then runs fill, drain and mixed passes that reach the full
// list. A behavioral list model predicts each result beat the table leaves open,
// and each beat is compared field by field in order. Both stream sides idle in random bursts.
// ============================================================================
module indexed_list_insert_erase_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP = ilie_pkg::MAX_BLOCKS * ilie_pkg::BLOCK_ENTRIES;
    localparam int N_RAND   = 1625;
    localparam int N_DIR    = 25;

    typedef struct packed {
        ilie_pkg::t_status status;
        logic [31:0]       rdata;
        logic [6:0]        count;
        logic [6:0]        cap;
    } t_list_result;

    typedef struct packed {
        ilie_pkg::t_req req;
        logic [6:0]     pos;
        logic [31:0]    val;
        logic           typed;
        t_list_result   res;
    } t_list_step;

    localparam t_list_step DIR_TAB [N_DIR] = '{
        '{ilie_pkg::REQ_READ, 7'd0, 32'h0, 1'b1, '{ilie_pkg::ST_RANGE, 32'h0, 7'd0, 7'd0}},
        '{ilie_pkg::REQ_ERASE, 7'd0, 32'h0, 1'b1, '{ilie_pkg::ST_RANGE, 32'h0, 7'd0, 7'd0}},
        '{ilie_pkg::REQ_INSERT, 7'd1, 32'h1, 1'b1, '{ilie_pkg::ST_RANGE, 32'h0, 7'd0, 7'd0}},
        '{ilie_pkg::REQ_APPEND, 7'd127, 32'h80000000, 1'b1,
          '{ilie_pkg::ST_OK, 32'h0, 7'd1, 7'd5}},
        '{ilie_pkg::REQ_INSERT, 7'd0, 32'h7FFFFFFF, 1'b1,
          '{ilie_pkg::ST_OK, 32'h0, 7'd2, 7'd5}},
        '{ilie_pkg::REQ_READ, 7'd0, 32'h0, 1'b1,
          '{ilie_pkg::ST_OK, 32'h7FFF_FFFF, 7'd2, 7'd5}},
        '{ilie_pkg::REQ_READ, 7'd1, 32'h0, 1'b1,
          '{ilie_pkg::ST_OK, 32'h8000_0000, 7'd2, 7'd5}},
        '{ilie_pkg::REQ_READ, 7'd2, 32'h0, 1'b1, '{ilie_pkg::ST_RANGE, 32'h0, 7'd2, 7'd5}},
        '{ilie_pkg::REQ_INSERT, 7'd2, 32'h0, 1'b1, '{ilie_pkg::ST_OK, 32'h0, 7'd3, 7'd5}},
        '{ilie_pkg::REQ_INSERT, 7'd127, 32'hFFFFFFFF, 1'b1,
          '{ilie_pkg::ST_RANGE, 32'h0, 7'd3, 7'd5}},
        '{ilie_pkg::REQ_ERASE, 7'd127, 32'h0, 1'b1, '{ilie_pkg::ST_RANGE, 32'h0, 7'd3, 7'd5}},
        '{ilie_pkg::REQ_READ, 7'd127, 32'h0, 1'b1, '{ilie_pkg::ST_RANGE, 32'h0, 7'd3, 7'd5}},
        '{ilie_pkg::REQ_APPEND, 7'd0, 32'hFFFFFFFF, 1'b1,
          '{ilie_pkg::ST_OK, 32'h0, 7'd4, 7'd5}},
        '{ilie_pkg::REQ_APPEND, 7'd0, 32'h1, 1'b1, '{ilie_pkg::ST_OK, 32'h0, 7'd5, 7'd5}},
        '{ilie_pkg::REQ_APPEND, 7'd0, 32'h2, 1'b1, '{ilie_pkg::ST_OK, 32'h0, 7'd6, 7'd10}},
        '{ilie_pkg::REQ_INSERT, 7'd3, 32'h5555_5555, 1'b0, '0},
        '{ilie_pkg::REQ_INSERT, 7'd7, 32'hAAAA_AAAA, 1'b0, '0},
        '{ilie_pkg::REQ_ERASE,  7'd0, 32'h0000_0000, 1'b0, '0},
        '{ilie_pkg::REQ_ERASE,  7'd6, 32'h0000_0000, 1'b0, '0},
        '{ilie_pkg::REQ_READ,   7'd0, 32'h0000_0000, 1'b0, '0},
        '{ilie_pkg::REQ_READ,   7'd5, 32'h0000_0000, 1'b0, '0},
        '{ilie_pkg::REQ_APPEND, 7'd55, 32'h1234_5678, 1'b0, '0},
        '{ilie_pkg::REQ_READ,   7'd6, 32'h0000_0000, 1'b0, '0},
        '{ilie_pkg::REQ_ERASE,  7'd4, 32'h0000_0000, 1'b0, '0},
        '{ilie_pkg::REQ_READ,   7'd4, 32'h0000_0000, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // position[6:0], item_value[38:7], pad
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // read_data[31:0], entry_count[38:32], capacity_now[45:39]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    // list model
    logic [31:0]  list_mem [LIST_CAP];
    int unsigned  list_cnt;
    int unsigned  list_blocks;
    int unsigned  peak_cnt;

    t_list_result result_q [$];
    t_list_result exp_r;

    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_req;
    int n_err;
    int n_beats;
    int n_ok;
    int n_range;
    int n_full;

    indexed_list_insert_erase_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_list_result list_apply(ilie_pkg::t_req req, logic [6:0] pos,
                                                logic [31:0] val);
        t_list_result r;
        int unsigned  at;
        int unsigned  i;
        r.status = ilie_pkg::ST_OK;
        r.rdata  = '0;
        case (req)
            ilie_pkg::REQ_APPEND, ilie_pkg::REQ_INSERT: begin
                if (req == ilie_pkg::REQ_INSERT && pos > list_cnt) begin
                    r.status = ilie_pkg::ST_RANGE;
                end else if (list_cnt >= list_blocks * ilie_pkg::BLOCK_ENTRIES &&
                             list_cnt >= LIST_CAP) begin
                    r.status = ilie_pkg::ST_FULL;
                end else begin
                    if (list_cnt >= list_blocks * ilie_pkg::BLOCK_ENTRIES) begin
                        if (list_blocks == 0)
                            list_blocks = 1;
                        else if (list_blocks * 2 > ilie_pkg::MAX_BLOCKS)
                            list_blocks = ilie_pkg::MAX_BLOCKS;
                        else
                            list_blocks = list_blocks * 2;
                    end
                    at = (req == ilie_pkg::REQ_APPEND) ? list_cnt : pos;
                    for (i = list_cnt; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = val;
                    list_cnt++;
                end
            end
            ilie_pkg::REQ_ERASE: begin
                if (pos >= list_cnt) begin
                    r.status = ilie_pkg::ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < list_cnt; i++)
                        list_mem[i] = list_mem[i+1];
                    list_cnt--;
                end
            end
            default: begin
                if (pos >= list_cnt)
                    r.status = ilie_pkg::ST_RANGE;
                else
                    r.rdata = list_mem[pos];
            end
        endcase
        case (r.status)
            ilie_pkg::ST_OK:    n_ok++;
            ilie_pkg::ST_RANGE: n_range++;
            default:            n_full++;
        endcase
        if (list_cnt > peak_cnt)
            peak_cnt = list_cnt;
        r.count = 7'(list_cnt);
        r.cap   = 7'(list_blocks * ilie_pkg::BLOCK_ENTRIES);
        return r;
    endfunction

    task automatic send_req(input ilie_pkg::t_req req, input logic [6:0] pos,
                            input logic [31:0] val,
                            input logic typed, input t_list_result typed_res);
        t_list_result r;
        int           gap;
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {1'b0, val, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        r = list_apply(req, pos, val);
        result_q.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge i_clk);
    endtask

    // receive side: random stall bursts plus one long hold on request
    initial begin
        int hold_left;
        int stall_left;
        hold_left     = 0;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                hold_left   = 400;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_beats++;
            if (result_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, tuser=%0d tdata=%h",
                         $time, m_axis_tuser, m_axis_tdata);
                n_err++;
            end else begin
                exp_r = result_q.pop_front();
                if (m_axis_tuser !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, m_axis_tuser);
                    n_err++;
                end
                if (m_axis_tdata[31:0] !== exp_r.rdata) begin
                    $display("%0t: read_data exp %h got %h", $time, exp_r.rdata,
                             m_axis_tdata[31:0]);
                    n_err++;
                end
                if (m_axis_tdata[38:32] !== exp_r.count) begin
                    $display("%0t: entry_count exp %0d got %0d", $time, exp_r.count,
                             m_axis_tdata[38:32]);
                    n_err++;
                end
                if (m_axis_tdata[45:39] !== exp_r.cap) begin
                    $display("%0t: capacity_now exp %0d got %0d", $time, exp_r.cap,
                             m_axis_tdata[45:39]);
                    n_err++;
                end
            end
        end
    end

    initial begin
        int             k;
        int             sel;
        int             w_app;
        int             w_ins;
        int             w_era;
        int             slot;
        ilie_pkg::t_req req;
        logic [6:0]     pos;
        logic [31:0]    val;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rx_hold_req   = 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        list_cnt      = 0;
        list_blocks   = 0;
        peak_cnt      = 0;
        n_err         = 0;
        n_beats       = 0;
        n_ok          = 0;
        n_range       = 0;
        n_full        = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++)
            send_req(DIR_TAB[k].req, DIR_TAB[k].pos, DIR_TAB[k].val,
                     DIR_TAB[k].typed, DIR_TAB[k].res);

        // passes of 550: fill to full and linger, drain toward empty, mixed
        for (k = 0; k < N_RAND; k++) begin
            if (k == 300) begin
                tx_idle_on  = 1'b0;
                rx_hold_req = 1'b1;
            end
            if (k == 340)
                tx_idle_on = 1'b1;
            if (k == 500)
                drain_results();
            if (k == 600) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (k == 750) begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            if (k == N_RAND - 200) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end

            slot = k % 550;
            if (slot < 250) begin
                w_app = 45; w_ins = 85; w_era = 90;
            end else if (slot < 400) begin
                w_app = 8; w_ins = 15; w_era = 85;
            end else begin
                w_app = 25; w_ins = 50; w_era = 75;
            end
            sel = $urandom_range(0, 99);
            if (sel < w_app)
                req = ilie_pkg::REQ_APPEND;
            else if (sel < w_ins)
                req = ilie_pkg::REQ_INSERT;
            else if (sel < w_era)
                req = ilie_pkg::REQ_ERASE;
            else
                req = ilie_pkg::REQ_READ;

            if ($urandom_range(0, 9) < 8 && (req == ilie_pkg::REQ_INSERT || list_cnt > 0)) begin
                if (req == ilie_pkg::REQ_INSERT)
                    pos = 7'($urandom_range(0, list_cnt));
                else
                    pos = 7'($urandom_range(0, list_cnt - 1));
            end else begin
                pos = 7'($urandom_range(0, 127));
            end

            case ($urandom_range(0, 19))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'hFFFF_FFFF;
                3:       val = 32'h0000_0000;
                default: val = $urandom();
            endcase

            send_req(req, pos, val, 1'b0, '0);
        end

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("Ran %0d requests, %0d result beats checked: %0d ok, %0d out of range, %0d full.",
                 N_DIR + N_RAND, n_beats, n_ok, n_range, n_full);
        $display("List reached %0d entries with %0d blocks allocated.", peak_cnt, list_blocks);
        if (n_err == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
